/* sv/flow_table_linear_probe_defines.svh */
// Assertion macros used by the checker file.
`ifndef FLOW_TABLE_LINEAR_PROBE_DEFINES_SVH
`define FLOW_TABLE_LINEAR_PROBE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FLTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FLTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fltp_pkg.sv */
package fltp_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic probe_start;
        logic probe_step;
        logic finish;
    } fltp_ctl_t;

    typedef struct packed {
        logic reduce_done;
        logic probe_done;
    } fltp_sts_t;

endpackage

/* sv/fltp_datapath.sv */
module fltp_datapath
    import fltp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fltp_ctl_t   ctl,
    output fltp_sts_t   sts,
    input  logic [1:0]  command,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_in,
    input  logic [15:0] dst_port_in,
    input  logic        is_tcp,
    input  logic [31:0] payload_tag,
    input  logic [31:0] now,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] data_out,
    output logic [31:0] stamp_out,
    output logic [31:0] packets_seen
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [IDXW:0]   DEPTH_C = (IDXW + 1)'(TABLE_DEPTH);
    localparam logic [IDXW-1:0] LAST_C  = IDXW'(TABLE_DEPTH - 1);
    // ceil(2^(32+IDXW) / TABLE_DEPTH); bit 32 is set for every depth above one
    localparam logic [63:0] RECIP_C =
        ((64'd1 << (32 + IDXW)) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
    localparam logic [31:0] RECIP_LO_C = RECIP_C[31:0];

    // request
    logic [1:0]  cmd_reg;
    logic [95:0] key_reg;
    logic        tcp_reg;
    logic [31:0] tag_reg;
    logic [31:0] now_reg;

    // home slot reduction
    logic [31:0]     sum_reg;
    logic [IDXW-1:0] rem_reg;
    logic [1:0]      red_cnt_reg;
    logic [64:0]     prod_reg;
    logic [63:0]     prod_lo;
    logic [31:0]     quot;
    logic [31:0]     quot_mul;
    logic [IDXW-1:0] home_idx;

    // probe
    logic [IDXW-1:0] addr_reg;
    logic [IDXW:0]   issue_cnt_reg;
    logic            rd_vld_reg;
    logic [IDXW-1:0] q_addr_reg;
    logic            q_valid_reg;
    logic [95:0]     q_key_reg;
    logic [31:0]     q_data_reg;
    logic [32:0]     q_stamp_reg;
    logic            match_reg;
    logic [IDXW-1:0] match_addr_reg;
    logic [31:0]     match_data_reg;
    logic [31:0]     match_stamp_reg;
    logic            free_reg;
    logic [IDXW-1:0] free_addr_reg;

    // table
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [95:0]            key_mem   [TABLE_DEPTH];
    logic [31:0]            data_mem  [TABLE_DEPTH];
    logic [32:0]            stamp_mem [TABLE_DEPTH];

    // result
    logic [2:0]  status_reg;
    logic [7:0]  slot_reg;
    logic [31:0] data_reg;
    logic [31:0] stamp_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;

    logic issuing;
    logic hit;

    assign prod_lo   = 64'(sum_reg) * 64'(RECIP_LO_C);
    assign quot      = 32'(prod_reg >> (32 + IDXW));
    assign quot_mul  = quot * 32'(TABLE_DEPTH);
    assign home_idx  = POW2 ? sum_reg[IDXW-1:0] : rem_reg;
    assign issuing   = ctl.probe_step && (issue_cnt_reg < DEPTH_C);
    assign hit       = rd_vld_reg && !match_reg && q_valid_reg && (q_key_reg == key_reg);
    assign count_next = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;

    assign sts.reduce_done = POW2 || (red_cnt_reg == 2'd2);
    assign sts.probe_done  = match_reg || (!rd_vld_reg && (issue_cnt_reg == DEPTH_C));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            key_reg <= {src_addr, dst_addr, src_port_in, dst_port_in};
            tcp_reg <= is_tcp;
            tag_reg <= payload_tag;
            now_reg <= now;
            sum_reg <= src_addr + dst_addr + {16'd0, src_port_in} + {16'd0, dst_port_in};
            rem_reg <= '0;
        end
        else if (ctl.reduce_step)
        begin
            if (red_cnt_reg == 2'd0)
            begin
                prod_reg <= {1'b0, prod_lo} + {1'b0, sum_reg, 32'd0};
            end
            else
            begin
                rem_reg <= IDXW'(sum_reg - quot_mul);
            end
        end

        if (ctl.probe_start)
        begin
            addr_reg <= home_idx;
        end
        else if (issuing)
        begin
            addr_reg <= (addr_reg == LAST_C) ? '0 : addr_reg + 1'b1;
        end

        if (issuing)
        begin
            q_addr_reg  <= addr_reg;
            q_valid_reg <= valid_reg[addr_reg];
            q_key_reg   <= key_mem[addr_reg];
            q_data_reg  <= data_mem[addr_reg];
            q_stamp_reg <= stamp_mem[addr_reg];
        end

        if (hit)
        begin
            match_addr_reg  <= q_addr_reg;
            match_data_reg  <= q_data_reg;
            match_stamp_reg <= q_stamp_reg[31:0];
        end

        if (ctl.probe_step && rd_vld_reg && !q_valid_reg && !free_reg)
        begin
            free_addr_reg <= q_addr_reg;
        end

        if (ctl.finish)
        begin
            if (cmd_reg == CMD_INSERT && match_reg)
            begin
                stamp_mem[match_addr_reg] <= {tcp_reg, now_reg};
            end
            else if (cmd_reg == CMD_INSERT && free_reg)
            begin
                key_mem[free_addr_reg]   <= key_reg;
                data_mem[free_addr_reg]  <= tag_reg;
                stamp_mem[free_addr_reg] <= {tcp_reg, now_reg};
            end

            data_reg  <= '0;
            stamp_reg <= '0;
            slot_reg  <= '0;
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (match_reg)
                    begin
                        status_reg <= ST_UPDATED;
                        slot_reg   <= 8'(match_addr_reg);
                    end
                    else if (free_reg)
                    begin
                        status_reg <= ST_INSERTED;
                        slot_reg   <= 8'(free_addr_reg);
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                CMD_LOOKUP:
                begin
                    if (match_reg)
                    begin
                        status_reg <= ST_FOUND;
                        slot_reg   <= 8'(match_addr_reg);
                        data_reg   <= match_data_reg;
                        stamp_reg  <= match_stamp_reg;
                    end
                    else
                    begin
                        status_reg <= ST_NOT_FOUND;
                    end
                end
                CMD_DELETE:
                begin
                    if (match_reg)
                    begin
                        status_reg <= ST_DELETED;
                        slot_reg   <= 8'(match_addr_reg);
                    end
                    else
                    begin
                        status_reg <= ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_reg <= ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                red_cnt_reg <= '0;
            end
            else if (ctl.reduce_step)
            begin
                red_cnt_reg <= red_cnt_reg + 2'd1;
            end

            if (ctl.probe_start)
            begin
                issue_cnt_reg <= '0;
                rd_vld_reg    <= 1'b0;
                match_reg     <= 1'b0;
                free_reg      <= 1'b0;
            end
            else if (ctl.probe_step)
            begin
                rd_vld_reg <= issuing;
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (hit)
                begin
                    match_reg <= 1'b1;
                end
                if (rd_vld_reg && !q_valid_reg)
                begin
                    free_reg <= 1'b1;
                end
            end

            if (ctl.finish)
            begin
                if (cmd_reg == CMD_INSERT && (match_reg || free_reg))
                begin
                    count_reg <= count_next;
                end
                if (cmd_reg == CMD_INSERT && !match_reg && free_reg)
                begin
                    valid_reg[free_addr_reg] <= 1'b1;
                end
                if (cmd_reg == CMD_DELETE && match_reg)
                begin
                    valid_reg[match_addr_reg] <= 1'b0;
                end
            end
        end
    end

    assign status       = status_reg;
    assign slot         = slot_reg;
    assign data_out     = data_reg;
    assign stamp_out    = stamp_reg;
    assign packets_seen = count_reg;

endmodule

/* sv/fltp_ctrl.sv */
module fltp_ctrl
    import fltp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fltp_sts_t sts,
    output fltp_ctl_t ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (sts.reduce_done)
                begin
                    ctl.probe_start = 1'b1;
                    state_next      = S_PROBE;
                end
                else
                begin
                    ctl.reduce_step = 1'b1;
                end
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.probe_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/flow_table_linear_probe.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_ready  | command, src_addr, dst_addr, src_port_in,
//          |                      | dst_port_in, is_tcp, payload_tag, now
// output   | out_valid / out_ready| status, slot, data_out, stamp_out, packets_seen
//
// One transaction at a time; the entry table is read one slot per cycle.
// Each transaction loads, works out the home-slot remainder when TABLE_DEPTH
// is not a power of two, probes from the home slot up to the match or through
// every slot on a miss, then writes its result.
// Reset clears the valid bits and the counter at once; no clearing pass.
// A stalled result holds the block before its table write; a new request is
// taken while the previous result still waits.
module flow_table_linear_probe
    import fltp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_in,
    input  logic [15:0] dst_port_in,
    input  logic        is_tcp,
    input  logic [31:0] payload_tag,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] data_out,
    output logic [31:0] stamp_out,
    output logic [31:0] packets_seen
);

    fltp_ctl_t ctl;
    fltp_sts_t sts;

    fltp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    fltp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (command),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .src_port_in  (src_port_in),
        .dst_port_in  (dst_port_in),
        .is_tcp       (is_tcp),
        .payload_tag  (payload_tag),
        .now          (now),
        .status       (status),
        .slot         (slot),
        .data_out     (data_out),
        .stamp_out    (stamp_out),
        .packets_seen (packets_seen)
    );

endmodule

/* sv/fltp_checker.sv */
`include "flow_table_linear_probe_defines.svh"

module fltp_checker
    import fltp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  slot,
    input logic [31:0] data_out,
    input logic [31:0] stamp_out,
    input logic [31:0] packets_seen
);

    `FLTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot), "result dropped while stalled")
    `FLTP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")
    `FLTP_ASSERT_NOW(a_zero_data, out_valid && status != ST_FOUND, data_out == 32'd0 && stamp_out == 32'd0, "data on non-found result")
    `FLTP_ASSERT_NEXT(a_count_mono, 1'b1, packets_seen >= $past(packets_seen), "packet counter went down")

endmodule

bind flow_table_linear_probe fltp_checker u_fltp_checker (.*);

/* test/tb_flow_table_linear_probe.sv */
`timescale 1ns / 100ps

module tb_flow_table_linear_probe;
    import fltp_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        tcp;
        logic [31:0] tag;
        logic [31:0] stamp;
    } flow_req_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  slot;
        logic [31:0] data;
        logic [31:0] stamp;
        logic [31:0] count;
    } flow_rsp_t;

    typedef struct {
        flow_req_t req;
        bit        typed;
        flow_rsp_t rsp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic        is_tcp;
    logic [31:0] payload_tag;
    logic [31:0] now;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] data_out;
    logic [31:0] stamp_out;
    logic [31:0] packets_seen;

    flow_table_linear_probe u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .src_addr(src_addr), .dst_addr(dst_addr),
        .src_port_in(src_port_in), .dst_port_in(dst_port_in), .is_tcp(is_tcp),
        .payload_tag(payload_tag), .now(now),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot(slot), .data_out(data_out),
        .stamp_out(stamp_out), .packets_seen(packets_seen)
    );

    // shadow table
    bit          tbl_valid [DEPTH];
    logic [31:0] tbl_src   [DEPTH];
    logic [31:0] tbl_dst   [DEPTH];
    logic [31:0] tbl_ports [DEPTH];
    logic        tbl_tcp   [DEPTH];
    logic [31:0] tbl_data  [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    logic [31:0] flow_count;

    flow_rsp_t   pending_rsp[$];
    int          errors;
    int          n_sent;
    int          n_recv;
    int          n_full;
    int          n_upd;
    int          n_found;
    int          idle_cycles;
    bit          hold_off;
    bit          stim_done;
    flow_req_t   key_pool[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic flow_rsp_t apply_flow(flow_req_t r);
        flow_rsp_t   o;
        logic [31:0] ports;
        int          home;
        int          hit;
        int          free_k;
        int          k;
        ports  = {r.sport, r.dport};
        home   = int'((r.src + r.dst + 32'(r.sport) + 32'(r.dport)) % DEPTH);
        hit    = -1;
        free_k = -1;
        o      = '0;
        o.st   = ST_NOT_FOUND;
        for (int i = 0; i < DEPTH; i++)
        begin
            k = (home + i) % DEPTH;
            if (hit < 0 && tbl_valid[k] && tbl_src[k] == r.src && tbl_dst[k] == r.dst
                && tbl_ports[k] == ports)
                hit = k;
            if (free_k < 0 && !tbl_valid[k])
                free_k = k;
        end
        case (r.cmd)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    tbl_stamp[hit] = r.stamp;
                    tbl_tcp[hit]   = r.tcp;
                    o.st   = ST_UPDATED;
                    o.slot = 8'(hit);
                end
                else if (free_k >= 0)
                begin
                    tbl_valid[free_k] = 1'b1;
                    tbl_src[free_k]   = r.src;
                    tbl_dst[free_k]   = r.dst;
                    tbl_ports[free_k] = ports;
                    tbl_tcp[free_k]   = r.tcp;
                    tbl_data[free_k]  = r.tag;
                    tbl_stamp[free_k] = r.stamp;
                    o.st   = ST_INSERTED;
                    o.slot = 8'(free_k);
                end
                else
                    o.st = ST_FULL;
                if (o.st != ST_FULL && flow_count != 32'hFFFF_FFFF)
                    flow_count++;
            end
            CMD_LOOKUP:
                if (hit >= 0)
                begin
                    o.st    = ST_FOUND;
                    o.slot  = 8'(hit);
                    o.data  = tbl_data[hit];
                    o.stamp = tbl_stamp[hit];
                end
            CMD_DELETE:
                if (hit >= 0)
                begin
                    tbl_valid[hit] = 1'b0;
                    o.st   = ST_DELETED;
                    o.slot = 8'(hit);
                end
            default: ;
        endcase
        o.count = flow_count;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("tb: result %0d %s got %h want %h", n_recv, what, got, want);
    endtask

    task automatic send_flow(flow_req_t r, bit typed, flow_rsp_t want);
        flow_rsp_t p;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= r.cmd;
        src_addr    <= r.src;
        dst_addr    <= r.dst;
        src_port_in <= r.sport;
        dst_port_in <= r.dport;
        is_tcp      <= r.tcp;
        payload_tag <= r.tag;
        now         <= r.stamp;
        do
            @(posedge clk);
        while (!in_ready);
        p = apply_flow(r);
        if (typed && p != want)
        begin
            errors++;
            $display("tb: directed row %0d table disagrees with prediction", n_sent);
        end
        pending_rsp.push_back(p);
        n_sent++;
    endtask

    // output side
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                hold_left = $urandom_range(10, 40);
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 3) != 0) || stim_done;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("tb: unexpected transaction, status %0d", status);
            end
            else
            begin
                flow_rsp_t w;
                w = pending_rsp.pop_front();
                if (status != w.st)           report_mismatch("status", 32'(status), 32'(w.st));
                if (slot != w.slot)           report_mismatch("slot", 32'(slot), 32'(w.slot));
                if (data_out != w.data)       report_mismatch("data_out", data_out, w.data);
                if (stamp_out != w.stamp)     report_mismatch("stamp_out", stamp_out, w.stamp);
                if (packets_seen != w.count)  report_mismatch("packets_seen", packets_seen, w.count);
                if (w.st == ST_FULL)  n_full++;
                if (w.st == ST_UPDATED) n_upd++;
                if (w.st == ST_FOUND) n_found++;
            end
            n_recv++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic flow_req_t mk(logic [1:0] c, logic [31:0] s, logic [31:0] d,
                                     logic [15:0] sp, logic [15:0] dp, logic t,
                                     logic [31:0] g, logic [31:0] n);
        flow_req_t r;
        r = '{cmd: c, src: s, dst: d, sport: sp, dport: dp, tcp: t, tag: g, stamp: n};
        return r;
    endfunction

    function automatic flow_rsp_t rs(logic [2:0] st, logic [7:0] sl, logic [31:0] dd,
                                     logic [31:0] ts, logic [31:0] c);
        flow_rsp_t o;
        o = '{st: st, slot: sl, data: dd, stamp: ts, count: c};
        return o;
    endfunction

    function automatic flow_req_t rand_req(int phase);
        flow_req_t r;
        int pick;
        r = mk(2'($urandom_range(0, 2)), $urandom, $urandom, 16'($urandom), 16'($urandom),
               1'($urandom_range(0, 1)), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (phase == 0 && r.cmd != CMD_INSERT && $urandom_range(0, 1) == 0)
            r.cmd = CMD_INSERT;
        if (pick < 2)
            r.cmd = CMD_SPARE;
        else if (pick < 70 && key_pool.size() > 0)
        begin
            flow_req_t k;
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.src = k.src; r.dst = k.dst; r.sport = k.sport; r.dport = k.dport;
        end
        else if (pick < 85)
        begin
            // cluster keys onto few home slots
            r.src   = 32'($urandom_range(0, 15));
            r.dst   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            r.sport = 16'($urandom_range(0, 3));
            r.dport = 16'h0;
        end
        if (r.cmd == CMD_INSERT && key_pool.size() < 400)
            key_pool.push_back(r);
        return r;
    endfunction

    dir_row_t dir_rows[$];

    initial
    begin
        flow_req_t r;
        flow_rsp_t z;
        z = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_INSERT;
        src_addr = '0; dst_addr = '0; src_port_in = '0; dst_port_in = '0;
        is_tcp = 1'b0; payload_tag = '0; now = '0;
        errors = 0; n_sent = 0; n_recv = 0; n_full = 0; n_upd = 0; n_found = 0;
        idle_cycles = 0; hold_off = 1'b0; stim_done = 1'b0;
        flow_count = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1,
                             rs(ST_NOT_FOUND, 0, 0, 0, 0)});
        dir_rows.push_back('{mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0), 1,
                             rs(ST_NOT_FOUND, 0, 0, 0, 0)});
        dir_rows.push_back('{mk(CMD_INSERT, 0, 0, 0, 0, 0, 32'h1234, 32'h10), 1,
                             rs(ST_INSERTED, 0, 0, 0, 1)});
        dir_rows.push_back('{mk(CMD_INSERT, 0, 0, 0, 0, 1, 32'h9999, 32'h20), 1,
                             rs(ST_UPDATED, 0, 0, 0, 2)});
        dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1,
                             rs(ST_FOUND, 0, 32'h1234, 32'h20, 2)});
        dir_rows.push_back('{mk(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, z});
        dir_rows.push_back('{mk(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                0, 0, 0), 0, z});
        dir_rows.push_back('{mk(CMD_INSERT, 32'd1, 0, 0, 16'hFFFF, 0, 32'hA5, 32'h5), 0, z});
        dir_rows.push_back('{mk(CMD_INSERT, 0, 32'd1, 16'hFFFF, 0, 1, 32'h5A, 32'h6), 0, z});
        dir_rows.push_back('{mk(CMD_LOOKUP, 0, 32'd1, 16'hFFFF, 0, 0, 0, 0), 0, z});
        dir_rows.push_back('{mk(CMD_SPARE, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 32'h1), 0, z});
        dir_rows.push_back('{mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0), 0, z});
        dir_rows.push_back('{mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 0, z});
        dir_rows.push_back('{mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0), 0, z});
        dir_rows.push_back('{mk(CMD_LOOKUP, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                                16'h8000, 1, 0, 0), 0, z});
        foreach (dir_rows[i])
            send_flow(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        // fill the table completely, then probe the full case
        for (int i = 0; i < DEPTH + 4; i++)
        begin
            r = mk(CMD_INSERT, 32'($urandom_range(0, 7)) << 8, $urandom, 16'($urandom),
                   16'($urandom), 1'($urandom_range(0, 1)), $urandom, $urandom);
            if (i == 20)
                hold_off = 1'b1;
            if (i == 20 + 200)
                hold_off = 1'b0;
            fork
                if (i == 20)
                begin
                    repeat (400) @(posedge clk);
                    hold_off = 1'b0;
                end
            join_none
            send_flow(r, 1'b0, z);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            r = mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0);
            r.src = 32'($urandom_range(0, 7)) << 8;
            if (tbl_valid[i])
            begin
                r.src = tbl_src[i]; r.dst = tbl_dst[i];
                r.sport = tbl_ports[i][31:16]; r.dport = tbl_ports[i][15:0];
            end
            send_flow(r, 1'b0, z);
        end

        for (int i = 0; i < 870; i++)
            send_flow(rand_req(i < 300 ? 0 : 1), 1'b0, z);
        in_valid <= 1'b0;

        stim_done = 1'b1;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 20) @(posedge clk);

        $display("tb: %0d transactions sent, %0d results checked", n_sent, n_recv);
        $display("tb: covered %0d table-full, %0d updates, %0d lookup hits", n_full,
                 n_upd, n_found);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/fltp_pkg.sv
sv/fltp_datapath.sv
sv/fltp_ctrl.sv
sv/flow_table_linear_probe.sv
sv/fltp_checker.sv
test/tb_flow_table_linear_probe.sv
